// File: rtl/monotonic_polyline_projection_top_defines.svh
// Assertion macros shared by the RTL.
`ifndef MONOTONIC_POLYLINE_PROJECTION_TOP_DEFINES_SVH
`define MONOTONIC_POLYLINE_PROJECTION_TOP_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define MPP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mpp assertion failed");

// antecedent implies consequent in the next cycle
`define MPP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mpp assertion failed");

`endif

// File: rtl/mpp_pkg.sv
package mpp_pkg;

  localparam int MAX_VERTICES = 1024;
  localparam int COORD_W      = 32;
  localparam int FRAC_BITS    = 16;

  localparam int ADDR_W = $clog2(MAX_VERTICES);
  localparam int CNT_W  = ADDR_W + 1;
  localparam int MUL_W  = COORD_W + 1;
  localparam int PROD_W = 2 * MUL_W;
  localparam int DOT_W  = PROD_W + 1;
  localparam int DIV_W  = PROD_W;
  localparam int DIST_W = 2 * COORD_W;
  localparam int TW     = FRAC_BITS + 1;
  localparam int RAM_W  = 3 * COORD_W;

  localparam logic [COORD_W-1:0] DTOL_RST = COORD_W'(655);
  localparam logic [COORD_W-1:0] FWIN_RST = COORD_W'(327680);

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;
  localparam logic [1:0] OP_RSVD   = 2'd3;

  localparam logic [1:0] ST_PROJ     = 2'd0;
  localparam logic [1:0] ST_FALLBACK = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;

  localparam logic CFG_DTOL = 1'b0;
  localparam logic CFG_FWIN = 1'b1;

  typedef struct packed {
    logic                 busy;
    logic                 rem_nz;
    logic [FRAC_BITS-1:0] quot;
  } div_res_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic        [COORD_W-1:0] arc;
    logic        [DIST_W-1:0]  dist_sq;
    logic        [1:0]         status;
  } res_t;

endpackage

// File: rtl/mpp_vtx_ram.sv
module mpp_vtx_ram #(
  parameter int DATA_W = 96,
  parameter int DEPTH  = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [DATA_W-1:0]        wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [DATA_W-1:0]        rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// File: rtl/mpp_div.sv
module mpp_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [mpp_pkg::DIV_W-1:0] dividend_i,
  input  logic [mpp_pkg::DIV_W-1:0] divisor_i,
  output mpp_pkg::div_res_t        res_o
);
  import mpp_pkg::*;

  localparam int DCNT_W = $clog2(FRAC_BITS);

  logic [DIV_W:0]         rem_q;
  logic [DIV_W-1:0]       dvs_q;
  logic [FRAC_BITS-1:0]   quot_q;
  logic [DCNT_W-1:0]      cnt_q;
  logic                   busy_q;
  logic [DIV_W:0]         shl;
  logic                   ge;

  assign shl = {rem_q[DIV_W-1:0], 1'b0};
  assign ge  = shl >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      rem_q  <= {1'b0, dividend_i};
      dvs_q  <= divisor_i;
      quot_q <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b1;
    end else if (busy_q) begin
      rem_q  <= ge ? shl - {1'b0, dvs_q} : shl;
      quot_q <= {quot_q[FRAC_BITS-2:0], ge};
      cnt_q  <= cnt_q + 1'b1;
      if (cnt_q == DCNT_W'(FRAC_BITS - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  assign res_o.busy   = busy_q;
  assign res_o.rem_nz = |rem_q;
  assign res_o.quot   = quot_q;

endmodule

// File: rtl/mpp_core.sv
module mpp_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            idle_o,
  input  logic [1:0]                      op_i,
  input  logic signed [mpp_pkg::COORD_W-1:0] point_x_i,
  input  logic signed [mpp_pkg::COORD_W-1:0] point_y_i,
  input  logic [mpp_pkg::COORD_W-1:0]     vertex_arc_in_i,
  input  logic [mpp_pkg::COORD_W-1:0]     dtol_i,
  input  logic [mpp_pkg::COORD_W-1:0]     fwin_i,
  output logic                            res_valid_o,
  input  logic                            res_ready_i,
  output mpp_pkg::res_t                   res_o
);
  import mpp_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_LD0, S_D1, S_D2, S_D3, S_ADV, S_SEG_LD, S_SEG_CHK,
    S_LL1, S_LL2, S_DT1, S_DT2, S_DOT, S_SEL, S_TDIV, S_TFIN,
    S_P1, S_P2, S_P3, S_P4, S_RES
  } state_e;

  localparam logic [TW-1:0] T_ONE = {1'b1, {FRAC_BITS{1'b0}}};

  state_e state_q;

  logic [CNT_W-1:0]           cnt_q, bidx_q, nxt;
  logic [COORD_W-1:0]         fr_q;
  logic                       fb_q, found_q;
  logic signed [COORD_W-1:0]  qx_q, qy_q, ax_q, ay_q, bx_q, by_q;
  logic [COORD_W-1:0]         asa_q, bea_q;
  logic signed [MUL_W-1:0]    vx_q, vy_q, dqx_q, dqy_q, de_q;
  logic signed [PROD_W-1:0]   prod_q, acc_q;
  logic [PROD_W-1:0]          len2_q;
  logic signed [DOT_W-1:0]    dot_q;
  logic                       t_div_q, t_one_q, mt_act_q, mt_one_q;
  logic [TW-1:0]              t_q;
  logic signed [COORD_W-1:0]  px_q, py_q, best_x_q, best_y_q;
  logic [COORD_W-1:0]         parc_q, best_arc_q;
  logic [PROD_W-1:0]          best_full_q;
  logic [1:0]                 status_q;

  logic                       ram_we, ram_re;
  logic [ADDR_W-1:0]          ram_raddr;
  logic [RAM_W-1:0]           rdata;
  logic signed [COORD_W-1:0]  rx, ry;
  logic [COORD_W-1:0]         rarc;

  logic signed [MUL_W-1:0]    mul_a, mul_b, dx, dy, t_s;
  logic signed [PROD_W-1:0]   mul_p;
  logic [PROD_W-1:0]          full;
  logic                       skip, dpos;
  logic [TW-1:0]              tt, mt;
  logic [COORD_W:0]           ea_tol, fr_win;
  div_res_t                   dv_t, dv_m;

  function automatic logic [COORD_W-1:0] rnd(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] s;
    s = p + (p[PROD_W-1] ? PROD_W'((1 << (FRAC_BITS - 1)) - 1)
                         : PROD_W'(1 << (FRAC_BITS - 1)));
    return s[FRAC_BITS+COORD_W-1:FRAC_BITS];
  endfunction

  assign rx   = rdata[COORD_W-1:0];
  assign ry   = rdata[2*COORD_W-1:COORD_W];
  assign rarc = rdata[3*COORD_W-1:2*COORD_W];

  assign ram_we = (state_q == S_IDLE) && in_valid_i && (op_i == OP_APPEND) &&
                  (cnt_q < CNT_W'(MAX_VERTICES));
  assign nxt    = fb_q ? CNT_W'(1) : bidx_q + 1'b1;

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = '0;
    if (state_q == S_IDLE && in_valid_i && op_i == OP_QUERY && cnt_q != '0) begin
      ram_re = 1'b1;
    end else if (state_q == S_ADV && nxt < cnt_q) begin
      ram_re    = 1'b1;
      ram_raddr = nxt[ADDR_W-1:0];
    end
  end

  mpp_vtx_ram #(
    .DATA_W (RAM_W),
    .DEPTH  (MAX_VERTICES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cnt_q[ADDR_W-1:0]),
    .wdata_i ({vertex_arc_in_i, point_y_i, point_x_i}),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (rdata)
  );

  mpp_div u_div_t (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (state_q == S_SEL),
    .dividend_i (dot_q[DIV_W-1:0]),
    .divisor_i  (len2_q),
    .res_o      (dv_t)
  );

  mpp_div u_div_m (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (state_q == S_SEL),
    .dividend_i ({{(DIV_W-COORD_W){1'b0}}, fr_q - asa_q}),
    .divisor_i  ({{(DIV_W-COORD_W){1'b0}}, bea_q - asa_q}),
    .res_o      (dv_m)
  );

  assign dx  = {qx_q[COORD_W-1], qx_q} - {px_q[COORD_W-1], px_q};
  assign dy  = {qy_q[COORD_W-1], qy_q} - {py_q[COORD_W-1], py_q};
  assign t_s = $signed({{(MUL_W-TW){1'b0}}, t_q});

  always_comb begin
    case (state_q)
      S_LL1:   begin mul_a = vx_q;  mul_b = vx_q; end
      S_LL2:   begin mul_a = vy_q;  mul_b = vy_q; end
      S_DT1:   begin mul_a = dqx_q; mul_b = vx_q; end
      S_DT2:   begin mul_a = dqy_q; mul_b = vy_q; end
      S_P1:    begin mul_a = vx_q;  mul_b = t_s;  end
      S_P2:    begin mul_a = vy_q;  mul_b = t_s;  end
      S_P3:    begin mul_a = de_q;  mul_b = t_s;  end
      S_D1:    begin mul_a = dx;    mul_b = dx;   end
      S_D2:    begin mul_a = dy;    mul_b = dy;   end
      default: begin mul_a = '0;    mul_b = '0;   end
    endcase
  end

  assign mul_p  = mul_a * mul_b;
  assign full   = acc_q + prod_q;
  assign ea_tol = {1'b0, bea_q} + {1'b0, dtol_i};
  assign fr_win = {1'b0, fr_q} + {1'b0, fwin_i};
  assign skip   = (ea_tol < {1'b0, fr_q}) || ({1'b0, asa_q} > fr_win);
  assign dpos   = !dot_q[DOT_W-1] && (dot_q != '0);
  assign tt     = t_div_q ? {1'b0, dv_t.quot} : (t_one_q ? T_ONE : '0);
  assign mt     = !mt_act_q ? '0 :
                  (mt_one_q ? T_ONE : {1'b0, dv_m.quot} + TW'(dv_m.rem_nz));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      fr_q    <= '0;
      bidx_q  <= '0;
      fb_q    <= 1'b0;
      found_q <= 1'b0;
    end else begin
      prod_q <= mul_p;
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            unique case (op_i)
              OP_CLEAR: begin
                cnt_q <= '0;
                fr_q  <= '0;
              end
              OP_APPEND: begin
                if (ram_we) begin
                  cnt_q <= cnt_q + 1'b1;
                end
              end
              OP_QUERY: begin
                qx_q <= point_x_i;
                qy_q <= point_y_i;
                if (cnt_q == '0) begin
                  best_x_q    <= '0;
                  best_y_q    <= '0;
                  best_arc_q  <= '0;
                  best_full_q <= '0;
                  status_q    <= ST_EMPTY;
                  state_q     <= S_RES;
                end else begin
                  state_q <= S_LD0;
                end
              end
              default: ;
            endcase
          end
        end
        S_LD0: begin
          ax_q    <= rx;
          ay_q    <= ry;
          asa_q   <= rarc;
          px_q    <= rx;
          py_q    <= ry;
          parc_q  <= rarc;
          fb_q    <= 1'b1;
          found_q <= 1'b0;
          state_q <= S_D1;
        end
        S_D1: state_q <= S_D2;
        S_D2: begin
          acc_q   <= prod_q;
          state_q <= S_D3;
        end
        S_D3: begin
          if (fb_q || !found_q || full < best_full_q) begin
            best_x_q    <= px_q;
            best_y_q    <= py_q;
            best_arc_q  <= parc_q;
            best_full_q <= full;
            found_q     <= !fb_q;
          end
          state_q <= S_ADV;
        end
        S_ADV: begin
          fb_q <= 1'b0;
          if (nxt < cnt_q) begin
            bidx_q <= nxt;
            if (!fb_q) begin
              ax_q  <= bx_q;
              ay_q  <= by_q;
              asa_q <= bea_q;
            end
            state_q <= S_SEG_LD;
          end else begin
            fr_q     <= best_arc_q;
            status_q <= found_q ? ST_PROJ : ST_FALLBACK;
            state_q  <= S_RES;
          end
        end
        S_SEG_LD: begin
          bx_q    <= rx;
          by_q    <= ry;
          bea_q   <= rarc;
          state_q <= S_SEG_CHK;
        end
        S_SEG_CHK: begin
          vx_q    <= {bx_q[COORD_W-1], bx_q} - {ax_q[COORD_W-1], ax_q};
          vy_q    <= {by_q[COORD_W-1], by_q} - {ay_q[COORD_W-1], ay_q};
          dqx_q   <= {qx_q[COORD_W-1], qx_q} - {ax_q[COORD_W-1], ax_q};
          dqy_q   <= {qy_q[COORD_W-1], qy_q} - {ay_q[COORD_W-1], ay_q};
          de_q    <= {1'b0, bea_q} - {1'b0, asa_q};
          state_q <= skip ? S_ADV : S_LL1;
        end
        S_LL1: state_q <= S_LL2;
        S_LL2: begin
          acc_q   <= prod_q;
          state_q <= S_DT1;
        end
        S_DT1: begin
          len2_q  <= acc_q + prod_q;
          state_q <= S_DT2;
        end
        S_DT2: begin
          acc_q   <= prod_q;
          state_q <= S_DOT;
        end
        S_DOT: begin
          dot_q   <= {acc_q[PROD_W-1], acc_q} + {prod_q[PROD_W-1], prod_q};
          state_q <= S_SEL;
        end
        S_SEL: begin
          // zero-length segment: t = 0, no frontier clamp
          if (vx_q == '0 && vy_q == '0) begin
            t_div_q  <= 1'b0;
            t_one_q  <= 1'b0;
            mt_act_q <= 1'b0;
          end else begin
            t_one_q  <= dpos && (dot_q[DIV_W-1:0] >= len2_q);
            t_div_q  <= dpos && (dot_q[DIV_W-1:0] < len2_q);
            mt_act_q <= (bea_q > asa_q) && (fr_q > asa_q);
          end
          mt_one_q <= (fr_q - asa_q) >= (bea_q - asa_q);
          state_q  <= S_TDIV;
        end
        S_TDIV: begin
          if (!dv_t.busy) begin
            state_q <= S_TFIN;
          end
        end
        S_TFIN: begin
          t_q     <= (tt > mt) ? tt : mt;
          state_q <= S_P1;
        end
        S_P1: state_q <= S_P2;
        S_P2: begin
          px_q    <= ax_q + rnd(prod_q);
          state_q <= S_P3;
        end
        S_P3: begin
          py_q    <= ay_q + rnd(prod_q);
          state_q <= S_P4;
        end
        S_P4: begin
          parc_q  <= asa_q + rnd(prod_q);
          state_q <= S_D1;
        end
        S_RES: begin
          if (res_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign idle_o      = state_q == S_IDLE;
  assign res_valid_o = state_q == S_RES;

  assign res_o.x       = best_x_q;
  assign res_o.y       = best_y_q;
  assign res_o.arc     = best_arc_q;
  assign res_o.dist_sq = (|best_full_q[PROD_W-1:DIST_W]) ? {DIST_W{1'b1}}
                                                         : best_full_q[DIST_W-1:0];
  assign res_o.status  = status_q;

endmodule

// File: rtl/monotonic_polyline_projection_top.sv
// Projects query points onto a stored polyline, walking forward along it.
// Clear and append items are done from the idle state. A query has a setup
// phase, then skips each segment outside the arc window and works through
// each segment inside it in full: the segment loop runs through one vertex
// memory read per segment, one shared 33x33 multiplier used nine times, and
// two 16-step restoring dividers run side by side for t and for the frontier
// clamp. One item is worked at a time; a finished result waits in the output
// register while the next item is taken.
`include "monotonic_polyline_projection_top_defines.svh"

module monotonic_polyline_projection_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [1:0]                         op_i,
  input  logic signed [mpp_pkg::COORD_W-1:0] point_x_i,
  input  logic signed [mpp_pkg::COORD_W-1:0] point_y_i,
  input  logic [mpp_pkg::COORD_W-1:0]        vertex_arc_in_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [mpp_pkg::COORD_W-1:0] proj_x_o,
  output logic signed [mpp_pkg::COORD_W-1:0] proj_y_o,
  output logic [mpp_pkg::COORD_W-1:0]        proj_arc_o,
  output logic [mpp_pkg::DIST_W-1:0]         dist_sq_o,
  output logic [1:0]                         status_o,
  input  logic                               cfg_we_i,
  input  logic                               cfg_index_i,
  input  logic [mpp_pkg::COORD_W-1:0]        cfg_wdata_i
);
  import mpp_pkg::*;

  logic [COORD_W-1:0] dtol_q, fwin_q;
  logic               idle, res_valid, res_ready;
  res_t               res, out_q;
  logic               out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dtol_q <= DTOL_RST;
      fwin_q <= FWIN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_DTOL: dtol_q <= cfg_wdata_i;
        CFG_FWIN: fwin_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  mpp_core u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .idle_o          (idle),
    .op_i            (op_i),
    .point_x_i       (point_x_i),
    .point_y_i       (point_y_i),
    .vertex_arc_in_i (vertex_arc_in_i),
    .dtol_i          (dtol_q),
    .fwin_i          (fwin_q),
    .res_valid_o     (res_valid),
    .res_ready_i     (res_ready),
    .res_o           (res)
  );

  assign in_stall_o = !idle;
  assign res_ready  = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
      out_q       <= res;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign proj_x_o    = out_q.x;
  assign proj_y_o    = out_q.y;
  assign proj_arc_o  = out_q.arc;
  assign dist_sq_o   = out_q.dist_sq;
  assign status_o    = out_q.status;

  `MPP_ASSERT_IMP(a_empty_zero, out_valid_o && status_o == ST_EMPTY, proj_arc_o == '0 && dist_sq_o == '0)
  `MPP_ASSERT_NXT(a_query_busy, in_valid_i && !in_stall_o && op_i == OP_QUERY, in_stall_o)
  `MPP_ASSERT_NXT(a_res_loaded, res_valid && res_ready, out_valid_o)

endmodule

// File: verif/mpp_checker.sv
`timescale 1ns / 1ps

module mpp_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  input  logic                               in_stall_i,
  input  logic [1:0]                         op_i,
  input  logic signed [mpp_pkg::COORD_W-1:0] point_x_i,
  input  logic signed [mpp_pkg::COORD_W-1:0] point_y_i,
  input  logic [mpp_pkg::COORD_W-1:0]        vertex_arc_in_i,
  input  logic                               out_valid_i,
  input  logic                               out_stall_i,
  input  logic signed [mpp_pkg::COORD_W-1:0] proj_x_i,
  input  logic signed [mpp_pkg::COORD_W-1:0] proj_y_i,
  input  logic [mpp_pkg::COORD_W-1:0]        proj_arc_i,
  input  logic [mpp_pkg::DIST_W-1:0]         dist_sq_i,
  input  logic [1:0]                         status_i,
  input  logic                               cfg_we_i,
  input  logic                               cfg_index_i,
  input  logic [mpp_pkg::COORD_W-1:0]        cfg_wdata_i,
  output int                                 fails_o,
  output int                                 pending_o,
  output int                                 results_o
);
  import mpp_pkg::*;

  typedef logic signed [127:0] wide_t;

  logic signed [COORD_W-1:0] vx_mem [MAX_VERTICES];
  logic signed [COORD_W-1:0] vy_mem [MAX_VERTICES];
  logic [COORD_W-1:0]        varc_mem [MAX_VERTICES];
  int                        vcount;
  logic [COORD_W-1:0]        frontier;
  logic [COORD_W-1:0]        dtol;
  logic [COORD_W-1:0]        fwin;
  res_t                      proj_q [$];

  function automatic wide_t scale_round(wide_t v, wide_t t);
    wide_t m;
    m = (((v < 0) ? -v : v) * t + 32768) >>> FRAC_BITS;
    return (v < 0) ? -m : m;
  endfunction

  function automatic res_t project(logic signed [COORD_W-1:0] qxi,
                                   logic signed [COORD_W-1:0] qyi);
    wide_t qx, qy, ax, ay, vx, vy, sa, ea, fr, len2, dot, t, mt, num, den;
    wide_t px, py, full, bfull, bx, by, barc;
    bit found;
    res_t r;
    found = 0;
    if (vcount == 0) begin
      r = '{x: '0, y: '0, arc: '0, dist_sq: '0, status: ST_EMPTY};
      return r;
    end
    qx = qxi;
    qy = qyi;
    fr = frontier;
    bx = vx_mem[0];
    by = vy_mem[0];
    barc = varc_mem[0];
    bfull = (qx - bx) * (qx - bx) + (qy - by) * (qy - by);
    for (int i = 0; i + 1 < vcount; i++) begin
      ax = vx_mem[i];
      ay = vy_mem[i];
      vx = wide_t'(vx_mem[i+1]) - ax;
      vy = wide_t'(vy_mem[i+1]) - ay;
      sa = varc_mem[i];
      ea = varc_mem[i+1];
      t = 0;
      if (ea + wide_t'(dtol) < fr) continue;
      if (sa > fr + wide_t'(fwin)) continue;
      if (vx != 0 || vy != 0) begin
        len2 = vx * vx + vy * vy;
        dot = (qx - ax) * vx + (qy - ay) * vy;
        if (dot <= 0) t = 0;
        else if (dot >= len2) t = 65536;
        else t = (dot <<< FRAC_BITS) / len2;
        if (ea > sa && fr > sa) begin
          num = fr - sa;
          den = ea - sa;
          if (num >= den) mt = 65536;
          else begin
            mt = (num <<< FRAC_BITS) / den;
            if ((num <<< FRAC_BITS) % den != 0) mt = mt + 1;
          end
          if (t < mt) t = mt;
        end
      end
      px = ax + scale_round(vx, t);
      py = ay + scale_round(vy, t);
      full = (qx - px) * (qx - px) + (qy - py) * (qy - py);
      if (!found || full < bfull) begin
        found = 1;
        bfull = full;
        bx = px;
        by = py;
        barc = sa + scale_round(ea - sa, t);
      end
    end
    r.x = bx[COORD_W-1:0];
    r.y = by[COORD_W-1:0];
    r.arc = barc[COORD_W-1:0];
    r.dist_sq = (bfull[127:64] != 0) ? '1 : bfull[63:0];
    r.status = found ? ST_PROJ : ST_FALLBACK;
    return r;
  endfunction

  assign pending_o = proj_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    res_t e;
    if (!rst_ni) begin
      vcount = 0;
      frontier = '0;
      dtol = DTOL_RST;
      fwin = FWIN_RST;
      proj_q.delete();
      fails_o = 0;
      results_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        results_o++;
        if (proj_q.size() == 0) begin
          $error("unexpected result");
          fails_o++;
        end else begin
          e = proj_q.pop_front();
          if (proj_x_i !== e.x) begin
            $error("proj_x exp %h got %h", e.x, proj_x_i); fails_o++;
          end
          if (proj_y_i !== e.y) begin
            $error("proj_y exp %h got %h", e.y, proj_y_i); fails_o++;
          end
          if (proj_arc_i !== e.arc) begin
            $error("proj_arc exp %h got %h", e.arc, proj_arc_i); fails_o++;
          end
          if (dist_sq_i !== e.dist_sq) begin
            $error("dist_sq exp %h got %h", e.dist_sq, dist_sq_i); fails_o++;
          end
          if (status_i !== e.status) begin
            $error("status exp %0d got %0d", e.status, status_i); fails_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        case (op_i)
          OP_CLEAR: begin
            vcount = 0;
            frontier = '0;
          end
          OP_APPEND: begin
            if (vcount < MAX_VERTICES) begin
              vx_mem[vcount] = point_x_i;
              vy_mem[vcount] = point_y_i;
              varc_mem[vcount] = vertex_arc_in_i;
              vcount++;
            end
          end
          OP_QUERY: begin
            e = project(point_x_i, point_y_i);
            if (e.status != ST_EMPTY) frontier = e.arc;
            proj_q = {proj_q, e};
          end
          default: ;
        endcase
      end
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_DTOL) dtol = cfg_wdata_i;
        else fwin = cfg_wdata_i;
      end
    end
  end
endmodule

// File: verif/tb_monotonic_polyline_projection_top.sv
`timescale 1ns / 1ps

module tb_monotonic_polyline_projection_top;
  import mpp_pkg::*;

  logic                      clk_i, rst_ni;
  logic                      in_valid, in_stall;
  logic [1:0]                op;
  logic signed [COORD_W-1:0] px, py;
  logic [COORD_W-1:0]        parc;
  logic                      out_valid, out_stall;
  logic signed [COORD_W-1:0] proj_x, proj_y;
  logic [COORD_W-1:0]        proj_arc;
  logic [DIST_W-1:0]         dist_sq;
  logic [1:0]                status;
  logic                      cfg_we, cfg_index;
  logic [COORD_W-1:0]        cfg_wdata;
  int                        fails, pending, results;
  int                        items, queries, idle_cycles;

  monotonic_polyline_projection_top uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .op_i(op), .point_x_i(px), .point_y_i(py), .vertex_arc_in_i(parc),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .proj_x_o(proj_x), .proj_y_o(proj_y), .proj_arc_o(proj_arc),
    .dist_sq_o(dist_sq), .status_o(status),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_wdata_i(cfg_wdata)
  );

  mpp_checker chk (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .op_i(op), .point_x_i(px), .point_y_i(py), .vertex_arc_in_i(parc),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .proj_x_i(proj_x), .proj_y_i(proj_y), .proj_arc_i(proj_arc),
    .dist_sq_i(dist_sq), .status_i(status),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_wdata_i(cfg_wdata),
    .fails_o(fails), .pending_o(pending), .results_o(results)
  );

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= 200000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // result side: random stall per item, one long hold-off, quiet stretches
  initial begin
    int w, got;
    bit held;
    out_stall = 1;
    got = 0;
    held = 0;
    @(posedge rst_ni);
    forever begin
      if (!held && got == 60) begin
        held = 1;
        out_stall <= 1;
        repeat (400) @(posedge clk_i);
      end
      w = (((got / 40) % 3) == 0) ? 0 : $urandom_range(0, 3);
      if (w > 0) begin
        out_stall <= 1;
        repeat (w) @(posedge clk_i);
      end
      out_stall <= 0;
      do @(posedge clk_i); while (!(out_valid && !out_stall));
      got++;
    end
  end

  task automatic send(logic [1:0] o, logic [31:0] x, logic [31:0] y, logic [31:0] a);
    int gap;
    gap = (((items / 50) % 4) == 1) ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1;
    op <= o;
    px <= x;
    py <= y;
    parc <= a;
    do @(posedge clk_i); while (in_stall);
    items++;
    if (o == OP_QUERY) queries++;
  endtask

  task automatic drain();
    in_valid <= 0;
    do @(posedge clk_i); while (pending != 0);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic set_cfg(logic [31:0] d, logic [31:0] f);
    drain();
    cfg_we <= 1;
    cfg_index <= CFG_DTOL;
    cfg_wdata <= d;
    @(posedge clk_i);
    cfg_index <= CFG_FWIN;
    cfg_wdata <= f;
    @(posedge clk_i);
    cfg_we <= 0;
  endtask

  function automatic logic [31:0] rnd_coord();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
      default: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
    endcase
  endfunction

  initial begin
    logic [31:0] sx [8], sy [8];
    logic [31:0] x, y, a;
    int n, k;
    rst_ni = 0;
    in_valid = 0;
    op = OP_CLEAR;
    px = '0;
    py = '0;
    parc = '0;
    cfg_we = 0;
    cfg_index = CFG_DTOL;
    cfg_wdata = '0;
    items = 0;
    queries = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed
    send(OP_QUERY, 32'h1234, 32'h5678, 0);
    send(OP_APPEND, 32'h0001_0000, 32'h0002_0000, 32'h0000_1000);
    send(OP_QUERY, 32'h8000_0000, 32'h7fff_ffff, 0);
    send(OP_APPEND, 32'h0001_0000, 32'h0002_0000, 32'h0000_1000);
    send(OP_APPEND, 32'h0005_0000, 32'h0002_0000, 32'h0005_0000);
    send(OP_APPEND, 32'h0005_0000, 32'h0006_0000, 32'h0009_0000);
    send(OP_QUERY, 32'hffff_0000, 32'h0002_0000, 0);
    send(OP_QUERY, 32'h0003_0000, 32'h0000_0000, 0);
    send(OP_QUERY, 32'h0001_0000, 32'h0002_0000, 0);
    send(OP_QUERY, 32'h0006_0000, 32'h0001_0000, 0);
    send(OP_QUERY, 32'h0009_0000, 32'h0009_0000, 0);
    send(OP_RSVD, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send(OP_QUERY, 32'h7fff_ffff, 32'h8000_0000, 0);
    send(OP_CLEAR, 0, 0, 0);
    send(OP_APPEND, 32'h8000_0000, 32'h8000_0000, 32'h0);
    send(OP_APPEND, 32'h7fff_ffff, 32'h7fff_ffff, 32'hffff_ffff);
    send(OP_QUERY, 32'h7fff_ffff, 32'h8000_0000, 0);
    send(OP_QUERY, 32'h0, 32'h0, 0);
    set_cfg(32'h0, 32'h0);
    send(OP_QUERY, 32'h8000_0000, 32'h8000_0000, 0);
    send(OP_QUERY, 32'h1000_0000, 32'h1000_0000, 0);
    set_cfg(32'hffff_ffff, 32'hffff_ffff);
    send(OP_QUERY, 32'h8000_0000, 32'h8000_0000, 0);
    send(OP_QUERY, 32'h0000_0000, 32'h7fff_0000, 0);

    // random polylines with queries near their vertices or at random points
    while (items < 540) begin
      if (items % 110 < 10 && pending == 0) begin
        case ($urandom_range(0, 3))
          0: set_cfg(DTOL_RST, FWIN_RST);
          1: set_cfg($urandom, $urandom);
          2: set_cfg($urandom_range(0, 4000), $urandom_range(0, 32'h0004_0000));
          default: set_cfg(32'hffff_ffff, 32'h0);
        endcase
      end
      if ($urandom_range(0, 4) != 0) send(OP_CLEAR, $urandom, $urandom, $urandom);
      n = $urandom_range(0, 8);
      x = rnd_coord();
      y = rnd_coord();
      a = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 32'h0002_0000);
      for (int i = 0; i < n; i++) begin
        sx[i] = x;
        sy[i] = y;
        send(OP_APPEND, x, y, a);
        if ($urandom_range(0, 5) != 0) begin
          x = x + $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
          y = y + $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
        end
        a = ($urandom_range(0, 9) == 0) ? $urandom : a + $urandom_range(0, 32'h0002_0000);
      end
      k = $urandom_range(1, 6);
      for (int j = 0; j < k; j++) begin
        if (n > 0 && $urandom_range(0, 4) != 0) begin
          x = sx[$urandom_range(0, n - 1)] + $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
          y = sy[$urandom_range(0, n - 1)] + $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
        end else begin
          x = rnd_coord();
          y = rnd_coord();
        end
        send(OP_QUERY, x, y, $urandom);
      end
      if ($urandom_range(0, 9) == 0) send(OP_RSVD, $urandom, $urandom, $urandom);
    end

    drain();
    repeat (50) @(posedge clk_i);
    $display("Covered %0d items, %0d queries, %0d results checked.", items, queries, results);
    $display("Included empty, single-vertex, zero-length and extreme-window cases.");
    if (fails == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
